/* rtl/cabp_pkg.sv */
package cabp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR  = 3'd4;

  // reset values of the clip rectangle and color
  localparam logic signed [15:0] CLIP_LEFT_RST   = 16'sd0;
  localparam logic signed [15:0] CLIP_TOP_RST    = 16'sd0;
  localparam logic signed [15:0] CLIP_RIGHT_RST  = 16'sd1024;
  localparam logic signed [15:0] CLIP_BOTTOM_RST = 16'sd768;
  localparam logic [31:0]        DRAW_COLOR_RST  = 32'h0000_0000;

  // drawing functions
  localparam logic FUNC_FILL = 1'b0;
  localparam logic FUNC_BLIT = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam int unsigned NUM_CH = 3;

  // input beat
  typedef struct packed {
    logic               func;
    logic signed [15:0] pix_x;
    logic signed [15:0] pix_y;
    logic [31:0]        dst_pixel;
    logic [31:0]        src_pixel;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic        write_enable;
    logic [31:0] new_pixel;
  } out_beat_t;

  // after stage 1: clip decision and first products
  typedef struct packed {
    logic                   we;
    logic                   fill_copy;
    logic                   func;
    logic [31:0]            dst_pixel;
    logic [31:0]            color;
    logic [NUM_CH-1:0][15:0] fill_c;
    logic [NUM_CH-1:0][15:0] fill_d;
    logic [NUM_CH-1:0][15:0] src_col;
    logic [15:0]            sa_prod;
  } s1_beat_t;

  // after stage 2: scaled terms, ready for the final add and select
  typedef struct packed {
    logic                   we;
    logic                   fill_copy;
    logic                   func;
    logic [31:0]            dst_pixel;
    logic [31:0]            color;
    logic [NUM_CH-1:0][7:0] fill_v;
    logic [NUM_CH-1:0][7:0] blit_t;
    logic [NUM_CH-1:0][7:0] blit_d;
  } s2_beat_t;

endpackage

/* rtl/clipped_alpha_blend_pixel.sv */
// channel | direction | beat                         | handshake
// in_     | input     | in_beat_t (func, x, y, dst, src) | in_valid / in_ready
// out_    | output    | out_beat_t (write_enable, new_pixel) | out_valid / out_ready
// cfg_    | input     | cfg_index, cfg_data          | cfg_valid / cfg_ready
//
// three register stages: clip test and 8x8 products, alpha scaling and
// 16x8 tint products, final add and select into the output register.
// one beat per cycle while out_ready is high; an accepted beat is registered in stage 1,
// stage 2 and then the output register, which drives out_valid. reset clears the stage
// valid bits and loads the clip rectangle and color. each stage advances when it is empty
// or the next one takes its beat, so a stall on out_ready backs up stage by stage; cfg_ready is always high.
module clipped_alpha_blend_pixel import cabp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_beat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic signed [15:0] clip_left_r;
  logic signed [15:0] clip_top_r;
  logic signed [15:0] clip_right_r;
  logic signed [15:0] clip_bottom_r;
  logic [31:0]        draw_color_r;

  logic     s1_valid;
  logic     s1_ready;
  s1_beat_t s1_beat;
  logic     s2_valid;
  logic     s2_ready;
  s2_beat_t s2_beat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= CLIP_LEFT_RST;
      clip_top_r    <= CLIP_TOP_RST;
      clip_right_r  <= CLIP_RIGHT_RST;
      clip_bottom_r <= CLIP_BOTTOM_RST;
      draw_color_r  <= DRAW_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLIP_LEFT:   clip_left_r   <= cfg_data[15:0];
        CFG_CLIP_TOP:    clip_top_r    <= cfg_data[15:0];
        CFG_CLIP_RIGHT:  clip_right_r  <= cfg_data[15:0];
        CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_data[15:0];
        CFG_DRAW_COLOR:  draw_color_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: clip and first products
  cabp_clip_stage u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_beat     (in_beat),
    .clip_left   (clip_left_r),
    .clip_top    (clip_top_r),
    .clip_right  (clip_right_r),
    .clip_bottom (clip_bottom_r),
    .draw_color  (draw_color_r),
    .out_valid   (s1_valid),
    .out_ready   (s1_ready),
    .out_beat    (s1_beat)
  );

  // stage 2: alpha scaling
  cabp_scale_stage u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_beat   (s1_beat),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_beat  (s2_beat)
  );

  // stage 3: blend and output register
  cabp_blend_stage u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_beat   (s2_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

/* rtl/cabp_clip_stage.sv */
module cabp_clip_stage import cabp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_beat_t           in_beat,
  input  logic signed [15:0] clip_left,
  input  logic signed [15:0] clip_top,
  input  logic signed [15:0] clip_right,
  input  logic signed [15:0] clip_bottom,
  input  logic [31:0]        draw_color,
  output logic               out_valid,
  input  logic               out_ready,
  output s1_beat_t           out_beat
);

  logic     valid_r;
  s1_beat_t beat_r;
  s1_beat_t beat_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  // clip test and the 8x8 products of both blend forms
  always_comb begin
    logic [7:0] ca;
    logic [7:0] ia;
    logic       in_rect;
    ca = draw_color[31:24];
    ia = ALPHA_OPAQUE - ca;
    in_rect = (in_beat.pix_x >= clip_left) && (in_beat.pix_x < clip_right) &&
              (in_beat.pix_y >= clip_top) && (in_beat.pix_y < clip_bottom);
    beat_nxt.we        = in_rect && (ca != 8'd0);
    beat_nxt.fill_copy = (ca == ALPHA_OPAQUE);
    beat_nxt.func      = in_beat.func;
    beat_nxt.dst_pixel = in_beat.dst_pixel;
    beat_nxt.color     = draw_color;
    beat_nxt.sa_prod   = {8'd0, in_beat.src_pixel[31:24]} * {8'd0, ca};
    for (int ch = 0; ch < NUM_CH; ch++) begin
      beat_nxt.fill_c[ch]  = {8'd0, draw_color[8*ch +: 8]} * {8'd0, ca};
      beat_nxt.fill_d[ch]  = {8'd0, in_beat.dst_pixel[8*ch +: 8]} * {8'd0, ia};
      beat_nxt.src_col[ch] = {8'd0, in_beat.src_pixel[8*ch +: 8]} *
                             {8'd0, draw_color[8*ch +: 8]};
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

/* rtl/cabp_scale_stage.sv */
module cabp_scale_stage import cabp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  s1_beat_t in_beat,
  output logic     out_valid,
  input  logic     out_ready,
  output s2_beat_t out_beat
);

  logic     valid_r;
  s2_beat_t beat_r;
  s2_beat_t beat_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  // scaled source alpha, tinted source term, destination term, fill sum
  always_comb begin
    logic [7:0]  sa;
    logic [7:0]  ia;
    logic [23:0] tprod;
    logic [15:0] dprod;
    logic [16:0] fsum;
    sa    = in_beat.sa_prod[15:8];
    ia    = ALPHA_OPAQUE - sa;
    tprod = '0;
    dprod = '0;
    fsum  = '0;
    beat_nxt.we        = in_beat.we;
    beat_nxt.fill_copy = in_beat.fill_copy;
    beat_nxt.func      = in_beat.func;
    beat_nxt.dst_pixel = in_beat.dst_pixel;
    beat_nxt.color     = in_beat.color;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tprod = {8'd0, in_beat.src_col[ch]} * {16'd0, sa};
      dprod = {8'd0, in_beat.dst_pixel[8*ch +: 8]} * {8'd0, ia};
      fsum  = {1'b0, in_beat.fill_c[ch]} + {1'b0, in_beat.fill_d[ch]};
      beat_nxt.blit_t[ch] = tprod[23:16];
      beat_nxt.blit_d[ch] = dprod[15:8];
      beat_nxt.fill_v[ch] = fsum[15:8];
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

/* rtl/cabp_blend_stage.sv */
module cabp_blend_stage import cabp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  s2_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      valid_r;
  out_beat_t beat_r;
  out_beat_t beat_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  // final add of the blit terms and selection of the written pixel
  always_comb begin
    logic [31:0] fill_px;
    logic [31:0] blit_px;
    fill_px = {in_beat.dst_pixel[31:24], 24'd0};
    blit_px = {in_beat.dst_pixel[31:24], 24'd0};
    for (int ch = 0; ch < NUM_CH; ch++) begin
      fill_px[8*ch +: 8] = in_beat.fill_v[ch];
      blit_px[8*ch +: 8] = in_beat.blit_t[ch] + in_beat.blit_d[ch];
    end
    beat_nxt.write_enable = in_beat.we;
    if (!in_beat.we) begin
      beat_nxt.new_pixel = in_beat.dst_pixel;
    end else if (in_beat.func == FUNC_BLIT) begin
      beat_nxt.new_pixel = blit_px;
    end else if (in_beat.fill_copy) begin
      beat_nxt.new_pixel = in_beat.color;
    end else begin
      beat_nxt.new_pixel = fill_px;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

/* rtl/cabp_checker.sv */
module cabp_checker import cabp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat dropped or changed while stalled");

  // input backpressure only when the whole pipe is full and the output stalls
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while pipeline has room");

  // an accepted beat reaches the output when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind clipped_alpha_blend_pixel cabp_checker u_cabp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);

/* sim/blend_checker.sv */
`timescale 1ns / 100ps

// watches the pixel, result and register channels, predicts each result beat
// and compares it field by field
module blend_checker import cabp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_beat_t             in_beat,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_beat_t            out_beat,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_cnt,
  output int                   outstanding,
  output int                   pix_cnt,
  output int                   wr_cnt,
  output int                   blit_cnt
);

  // own copy of the clip rectangle and draw color
  logic signed [15:0] clip_l = CLIP_LEFT_RST;
  logic signed [15:0] clip_t = CLIP_TOP_RST;
  logic signed [15:0] clip_r = CLIP_RIGHT_RST;
  logic signed [15:0] clip_b = CLIP_BOTTOM_RST;
  logic [31:0]        color  = DRAW_COLOR_RST;

  out_beat_t pending_px[$];
  int        fails   = 0;
  int        n_pix   = 0;
  int        n_wr    = 0;
  int        n_blit  = 0;

  initial begin
    fail_cnt    = 0;
    outstanding = 0;
    pix_cnt     = 0;
    wr_cnt      = 0;
    blit_cnt    = 0;
  end

  // clip test, then opaque copy, fill blend or tinted blit blend
  function automatic out_beat_t blend_pixel(input in_beat_t px);
    out_beat_t   res;
    logic        in_rect;
    logic [31:0] ca, sa, ia, c, d, s, v;
    int          ch;
    in_rect = ($signed(px.pix_x) >= clip_l) && ($signed(px.pix_x) < clip_r) &&
              ($signed(px.pix_y) >= clip_t) && ($signed(px.pix_y) < clip_b);
    ca = color[31:24];
    res.write_enable = in_rect && (ca != 0);
    res.new_pixel    = px.dst_pixel;
    if (res.write_enable) begin
      if (px.func == FUNC_FILL && ca == ALPHA_OPAQUE) begin
        res.new_pixel = color;
      end else begin
        sa = (px.func == FUNC_FILL) ? ca : ((px.src_pixel[31:24] * ca) >> 8);
        ia = ALPHA_OPAQUE - sa;
        // color channels only, destination alpha stays
        for (ch = 0; ch < NUM_CH; ch++) begin
          c = color[8*ch +: 8];
          d = px.dst_pixel[8*ch +: 8];
          s = px.src_pixel[8*ch +: 8];
          if (px.func == FUNC_FILL)
            v = (c * ca + d * ia) >> 8;
          else
            v = ((s * c * sa) >> 16) + ((d * ia) >> 8);
          res.new_pixel[8*ch +: 8] = v[7:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      clip_l = CLIP_LEFT_RST;
      clip_t = CLIP_TOP_RST;
      clip_r = CLIP_RIGHT_RST;
      clip_b = CLIP_BOTTOM_RST;
      color  = DRAW_COLOR_RST;
      pending_px.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_px.size() == 0) begin
          $error("result beat with no pixel pending: write_enable %0b new_pixel %08h",
                 out_beat.write_enable, out_beat.new_pixel);
          fails++;
        end else begin
          want = pending_px.pop_front();
          if (out_beat.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0b, got %0b",
                   want.write_enable, out_beat.write_enable);
            fails++;
          end
          if (out_beat.new_pixel !== want.new_pixel) begin
            $error("new_pixel: expected %08h, got %08h",
                   want.new_pixel, out_beat.new_pixel);
            fails++;
          end
        end
      end
      // accepted pixel beat uses the settings in force before this edge
      if (in_valid && in_ready) begin
        want = blend_pixel(in_beat);
        pending_px.push_back(want);
        n_pix++;
        if (want.write_enable) n_wr++;
        if (in_beat.func == FUNC_BLIT) n_blit++;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLIP_LEFT:   clip_l = cfg_data[15:0];
          CFG_CLIP_TOP:    clip_t = cfg_data[15:0];
          CFG_CLIP_RIGHT:  clip_r = cfg_data[15:0];
          CFG_CLIP_BOTTOM: clip_b = cfg_data[15:0];
          CFG_DRAW_COLOR:  color  = cfg_data;
          default: ;
        endcase
      end
    end
    fail_cnt    <= fails;
    outstanding <= pending_px.size();
    pix_cnt     <= n_pix;
    wr_cnt      <= n_wr;
    blit_cnt    <= n_blit;
  end

endmodule

/* sim/tb_clipped_alpha_blend_pixel.sv */
`timescale 1ns / 100ps

module tb_clipped_alpha_blend_pixel import cabp_pkg::*; ();

  localparam int LIMIT        = 200000;
  localparam int HOLD_CYCLES  = 40;
  localparam int IDLE_PCT     = 32;
  localparam int NUM_PHASES   = 11;
  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE       = 8;
  localparam int FAST_PHASE   = 2;
  localparam int HOLD_PHASE   = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_beat_t             in_beat   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CLIP_LEFT;
  logic [31:0]          cfg_data  = '0;

  int fail_cnt, outstanding, pix_cnt, wr_cnt, blit_cnt;
  int cycles      = 0;
  int in_idle_pct = IDLE_PCT;
  int rdy_idle_pct = IDLE_PCT;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int n_settings  = 0;
  int cur_l = 0, cur_t = 0, cur_r = 1024, cur_b = 768;

  always #4 clk = ~clk;

  clipped_alpha_blend_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blend_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_beat    (out_beat),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_cnt    (fail_cnt),
    .outstanding (outstanding),
    .pix_cnt     (pix_cnt),
    .wr_cnt      (wr_cnt),
    .blit_cnt    (blit_cnt)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rdy_idle_pct);
    end
  end

  // one pixel beat, after a random gap; valid stays up for the next call
  task automatic send_px(input logic f, input int x, input int y,
                         input logic [31:0] dst, input logic [31:0] src);
    in_beat_t b;
    b.func      = f;
    b.pix_x     = x[15:0];
    b.pix_y     = y[15:0];
    b.dst_pixel = dst;
    b.src_pixel = src;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input int l, input int t, input int r, input int bt,
                              input logic [31:0] col);
    write_reg(CFG_CLIP_LEFT, l);
    write_reg(CFG_CLIP_TOP, t);
    write_reg(CFG_CLIP_RIGHT, r);
    write_reg(CFG_CLIP_BOTTOM, bt);
    write_reg(CFG_DRAW_COLOR, col);
    cur_l = l;
    cur_t = t;
    cur_r = r;
    cur_b = bt;
    n_settings++;
  endtask

  // mostly around the clip edges, sometimes anywhere
  function automatic int pick_coord(input int lo, input int hi);
    if (hi < lo || $urandom_range(3) == 0) return int'($urandom);
    return int'(lo - 4 + $urandom_range(hi - lo + 8));
  endfunction

  initial begin
    int               ph, k, l, t, r, bt;
    logic [31:0]      col, dst, src;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: color alpha zero, so nothing is written
    send_px(FUNC_FILL, 5, 5, 32'h12345678, 32'h9abcdef0);
    send_px(FUNC_BLIT, 1023, 767, 32'hffffffff, 32'hffffffff);
    drain();

    // opaque color, small window and its edges
    load_setting(-10, -10, 10, 10, 32'hff336699);
    send_px(FUNC_FILL, -10, -10, 32'h00000000, 32'h00000000);
    send_px(FUNC_FILL, 9, 9, 32'hffffffff, 32'h00000000);
    send_px(FUNC_FILL, 10, 0, 32'h11223344, 32'h00000000);
    send_px(FUNC_FILL, 0, 10, 32'h11223344, 32'h00000000);
    send_px(FUNC_FILL, -11, 0, 32'h55667788, 32'h00000000);
    send_px(FUNC_BLIT, 0, -11, 32'h55667788, 32'hffffffff);
    send_px(FUNC_BLIT, 0, 0, 32'h80402010, 32'hffffffff);
    send_px(FUNC_BLIT, 1, 1, 32'hffffffff, 32'h00ffffff);
    drain();

    // half alpha over the widest rectangle; an unused index changes nothing
    load_setting(-32768, -32768, 32767, 32767, 32'h80ff00ff);
    write_reg(CFG_UNUSED, 32'hffffffff);
    send_px(FUNC_FILL, -32768, -32768, 32'h00000000, 32'h00000000);
    send_px(FUNC_FILL, 32767, 0, 32'hffffffff, 32'hffffffff);
    send_px(FUNC_FILL, 0, 32767, 32'hffffffff, 32'hffffffff);
    send_px(FUNC_FILL, 32766, 32766, 32'hffffffff, 32'hffffffff);
    send_px(FUNC_BLIT, -1, -1, 32'hffffffff, 32'hffffffff);
    send_px(FUNC_BLIT, 100, 100, 32'h00000000, 32'hff000000);
    drain();

    // smallest nonzero alpha, then full white tint
    load_setting(-32768, -32768, 32767, 32767, 32'h01ffffff);
    send_px(FUNC_FILL, 0, 0, 32'hffffffff, 32'h00000000);
    send_px(FUNC_BLIT, 0, 0, 32'h00000000, 32'hffffffff);
    drain();
    load_setting(-32768, -32768, 32767, 32767, 32'hffffffff);
    send_px(FUNC_BLIT, 0, 0, 32'h00000000, 32'hffffffff);
    send_px(FUNC_BLIT, 0, 0, 32'hffffffff, 32'h7f808080);
    drain();

    // inverted, then empty rectangle: nothing inside
    load_setting(100, 0, 50, 768, 32'hff00ff00);
    send_px(FUNC_FILL, 75, 10, 32'h01020304, 32'h00000000);
    send_px(FUNC_FILL, 100, 10, 32'h01020304, 32'h00000000);
    drain();
    load_setting(0, 20, 1024, 20, 32'hc0a0b0c0);
    send_px(FUNC_BLIT, 5, 20, 32'h01020304, 32'hffffffff);
    drain();

    // random phases, each with its own clip rectangle and color
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(3))
        0: begin
          l = -32768; t = -32768; r = 32767; bt = 32767;
        end
        1: begin
          l  = int'($urandom_range(600)) - 300;
          t  = int'($urandom_range(600)) - 300;
          r  = l + int'($urandom_range(200));
          bt = t + int'($urandom_range(200));
        end
        2: begin
          l  = int'($urandom_range(65535)) - 32768;
          t  = int'($urandom_range(65535)) - 32768;
          r  = int'($urandom_range(65535)) - 32768;
          bt = int'($urandom_range(65535)) - 32768;
        end
        default: begin
          l = 0; t = 0; r = 1024; bt = 768;
        end
      endcase
      col = $urandom;
      case ($urandom_range(3))
        0: col[31:24] = '0;
        1: col[31:24] = ALPHA_OPAQUE;
        2: col[31:24] = 8'd1;
        default: ;
      endcase
      load_setting(l, t, r, bt, col);

      // one phase at full speed, one with the result side held off
      in_idle_pct  = (ph == FAST_PHASE || ph == HOLD_PHASE) ? 0 : IDLE_PCT;
      rdy_idle_pct <= (ph == FAST_PHASE) ? 0 : IDLE_PCT;
      if (ph == HOLD_PHASE) hold_req <= hold_req + 1;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        dst = $urandom;
        src = $urandom;
        case ($urandom_range(7))
          0: src[31:24] = '0;
          1: src[31:24] = ALPHA_OPAQUE;
          default: ;
        endcase
        send_px(1'($urandom_range(1)), pick_coord(cur_l, cur_r), pick_coord(cur_t, cur_b),
                dst, src);
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("covered %0d pixels (%0d blits): %0d written, %0d left unwritten",
             pix_cnt, blit_cnt, wr_cnt, pix_cnt - wr_cnt);
    $display("over %0d clip and color settings, incl. a %0d-cycle result hold-off",
             n_settings, HOLD_CYCLES);
    if (fail_cnt == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/cabp_pkg.sv
rtl/cabp_clip_stage.sv
rtl/cabp_scale_stage.sv
rtl/cabp_blend_stage.sv
rtl/clipped_alpha_blend_pixel.sv
rtl/cabp_checker.sv
sim/blend_checker.sv
sim/tb_clipped_alpha_blend_pixel.sv
